>>> rtl/haar_pkg.sv
// ============================================================================
// haar_pkg: shared types and constants for the Haar feature evaluator
// Holds the request and result structs, field widths, register indexes,
// request function codes and corner codes.
// ============================================================================
package haar_pkg;

  // Field widths.
  localparam int POS_W      = 6;
  localparam int OFF_W      = 8;
  localparam int CRD_W      = 9;   // window position plus offset
  localparam int ENTRY_W    = 40;
  localparam int BOX_W      = 42;  // two adds and two subtracts of entries
  localparam int WT_W       = 16;
  localparam int FEAT_W     = 58;
  localparam int ACC_W      = 60;  // four products summed exactly
  localparam int CNT_W      = 3;
  localparam int BOUNDS_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int NUM_BOUNDS = 4;
  localparam int REG_SEL_W  = 2;
  localparam int CRN_W      = 2;

  // Default sizes.
  localparam int DEF_IMG_ROWS    = 64;
  localparam int DEF_IMG_COLS    = 64;
  localparam int DEF_MAX_REGIONS = 4;

  localparam logic [CNT_W-1:0] RESET_REGION_COUNT = 3'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS  = 3'd5;

  // Request function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  // Corner codes, in read order. D and A add, C and B subtract.
  localparam logic [CRN_W-1:0] CRN_D = 2'd0;  // (y2, x2)
  localparam logic [CRN_W-1:0] CRN_A = 2'd1;  // (y1-1, x1-1)
  localparam logic [CRN_W-1:0] CRN_C = 2'd2;  // (y2, x1-1)
  localparam logic [CRN_W-1:0] CRN_B = 2'd3;  // (y1-1, x2)

  typedef struct packed {
    logic                      func;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic signed [ENTRY_W-1:0] entry_value;
    logic [POS_W-1:0]          pos_x;
    logic [POS_W-1:0]          pos_y;
  } haar_req_t;

  typedef struct packed {
    logic signed [FEAT_W-1:0] feature_value;
    logic                     out_of_range;
  } haar_res_t;

endpackage

>>> rtl/haar_feature_from_integral_image.sv
// ============================================================================
// haar_feature_from_integral_image: Haar-like feature over an integral image
// Write requests fill a single-port integral image memory; evaluate requests
// sum up to four weighted rectangles at a window position.
// ============================================================================
// A write request (func 0) is taken while busy stays low. An evaluate
// request (func 1) holds busy high while the block works through n rectangles,
// n being the region count limited to MAX_REGIONS: a check state tests every
// corner against the image, then the single memory port reads four corners per
// rectangle, one a cycle, and the pipeline finishes the box sum, the weight
// product, the accumulation and the saturation. The result strobe comes in the
// same cycle as busy falls. When a corner falls outside the image, or n is zero,
// the reads are skipped and the check goes straight to the finishing state.
// Each result is on out_data for exactly one cycle with out_strobe high, and the
// receiver has no way to hold it off. The memory has no reset; evaluate only
// windows whose entries were written.
module haar_feature_from_integral_image
  import haar_pkg::*;
#(
  parameter int IMG_ROWS    = DEF_IMG_ROWS,
  parameter int IMG_COLS    = DEF_IMG_COLS,
  parameter int MAX_REGIONS = DEF_MAX_REGIONS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  haar_req_t             in_data,
  output logic                  out_strobe,
  output haar_res_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH = IMG_ROWS * IMG_COLS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_READ  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // Corner coordinate: window position plus unsigned offset.
  function automatic logic [CRD_W-1:0] crd(input logic [POS_W-1:0] p,
                                           input logic [OFF_W-1:0] o);
    return CRD_W'(p) + CRD_W'(o);
  endfunction

  // True when all four corners of a rectangle lie inside the image.
  function automatic logic region_ok(input logic [BOUNDS_W-1:0] b,
                                     input logic [POS_W-1:0]    px,
                                     input logic [POS_W-1:0]    py);
    logic [CRD_W-1:0] x1;
    logic [CRD_W-1:0] x2;
    logic [CRD_W-1:0] y1;
    logic [CRD_W-1:0] y2;
    x1 = crd(px, b[7:0]);
    x2 = crd(px, b[15:8]);
    y1 = crd(py, b[23:16]);
    y2 = crd(py, b[31:24]);
    return (x1 != '0) && (y1 != '0) &&
           (32'(x1) <= 32'(IMG_COLS)) && (32'(y1) <= 32'(IMG_ROWS)) &&
           (32'(x2) <  32'(IMG_COLS)) && (32'(y2) <  32'(IMG_ROWS));
  endfunction

  // Configuration registers.
  logic [CNT_W-1:0]    region_count_r;
  logic [BOUNDS_W-1:0] bounds_r [NUM_BOUNDS];
  logic [CFG_DATA_W-1:0] weights_r;

  // Sequencer and pipeline registers.
  state_t                    state_r, state_nxt;
  logic [REG_SEL_W+CRN_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]          n_r, n_nxt;
  logic                      bad_r, bad_nxt;
  logic [POS_W-1:0]          pos_x_r, pos_y_r;
  logic                      rd_vld_r, rd_last_r;
  logic [CRN_W-1:0]          rd_crn_r;
  logic [REG_SEL_W-1:0]      rd_reg_r;
  logic signed [ENTRY_W-1:0] mem_rdata_r;
  logic signed [BOX_W-1:0]   box_r, box_nxt;
  logic                      box_vld_r, box_last_r;
  logic [REG_SEL_W-1:0]      box_reg_r;
  logic signed [FEAT_W-1:0]  prod_r, prod_nxt;
  logic                      prod_vld_r, prod_last_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      out_strobe_r, out_strobe_nxt;
  haar_res_t                 out_data_r, out_data_nxt;

  logic signed [ENTRY_W-1:0] mem [DEPTH];

  // Region count limited to the supported number of rectangles.
  logic [CNT_W-1:0] n_sat;
  assign n_sat = (region_count_r > CNT_W'(MAX_REGIONS)) ? CNT_W'(MAX_REGIONS)
                                                        : region_count_r;

  // Bounds check over every rectangle in use.
  logic bad_any;
  always_comb begin
    bad_any = 1'b0;
    for (int k = 0; k < NUM_BOUNDS; k++) begin
      if ((CNT_W'(k) < n_sat) && !region_ok(bounds_r[k], pos_x_r, pos_y_r)) begin
        bad_any = 1'b1;
      end
    end
  end

  // Corner position of the current read.
  logic [BOUNDS_W-1:0] rd_bounds;
  logic [CRN_W-1:0]    rd_crn;
  logic [CRD_W-1:0]    rd_row, rd_col;
  logic                rd_last;
  assign rd_bounds = bounds_r[rd_cnt_r[REG_SEL_W+CRN_W-1:CRN_W]];
  assign rd_crn    = rd_cnt_r[CRN_W-1:0];
  always_comb begin
    if ((rd_crn == CRN_D) || (rd_crn == CRN_C)) begin
      rd_row = crd(pos_y_r, rd_bounds[31:24]);
    end else begin
      rd_row = crd(pos_y_r, rd_bounds[23:16]) - CRD_W'(1);
    end
    if ((rd_crn == CRN_D) || (rd_crn == CRN_B)) begin
      rd_col = crd(pos_x_r, rd_bounds[15:8]);
    end else begin
      rd_col = crd(pos_x_r, rd_bounds[7:0]) - CRD_W'(1);
    end
  end
  assign rd_last = (CNT_W'(rd_cnt_r[REG_SEL_W+CRN_W-1:CRN_W]) == n_r - CNT_W'(1)) &&
                   (rd_crn == CRN_B);

  // One memory port: writes while idle, corner reads while evaluating.
  logic             accept;
  logic             mem_we;
  logic [CRD_W-1:0] mem_row, mem_col;
  logic [AW-1:0]    mem_addr;
  assign accept   = start && !busy;
  assign mem_we   = accept && (in_data.func == FUNC_WRITE) &&
                    (32'(in_data.row) < 32'(IMG_ROWS)) &&
                    (32'(in_data.col) < 32'(IMG_COLS));
  assign mem_row  = busy ? rd_row : CRD_W'(in_data.row);
  assign mem_col  = busy ? rd_col : CRD_W'(in_data.col);
  assign mem_addr = AW'(mem_row) * AW'(IMG_COLS) + AW'(mem_col);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_data.entry_value;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  // Box sum: add D and A, subtract C and B.
  always_comb begin
    logic signed [BOX_W-1:0] base;
    logic signed [BOX_W-1:0] term;
    base = (rd_crn_r == CRN_D) ? '0 : box_r;
    term = BOX_W'(mem_rdata_r);
    if ((rd_crn_r == CRN_D) || (rd_crn_r == CRN_A)) begin
      box_nxt = base + term;
    end else begin
      box_nxt = base - term;
    end
  end

  // Weight product of a finished box sum.
  logic signed [WT_W-1:0] weight;
  assign weight   = weights_r[box_reg_r*WT_W +: WT_W];
  assign prod_nxt = box_r * weight;

  // Saturated result.
  logic [ACC_W-FEAT_W:0]   acc_hi;
  logic signed [FEAT_W-1:0] acc_sat;
  assign acc_hi = acc_r[ACC_W-1:FEAT_W-1];
  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      acc_sat = FEAT_W'(acc_r);
    end else if (acc_r[ACC_W-1]) begin
      acc_sat = {1'b1, {(FEAT_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(FEAT_W-1){1'b1}}};
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt      = state_r;
    rd_cnt_nxt     = rd_cnt_r;
    n_nxt          = n_r;
    bad_nxt        = bad_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_data.func == FUNC_EVAL)) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        n_nxt      = n_sat;
        bad_nxt    = bad_any;
        rd_cnt_nxt = '0;
        state_nxt  = ((n_sat == '0) || bad_any) ? S_DONE : S_READ;
      end
      S_READ: begin
        rd_cnt_nxt = rd_cnt_r + 1'b1;
        if (rd_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (prod_vld_r && prod_last_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        out_strobe_nxt = 1'b1;
        if (bad_r) begin
          out_data_nxt.feature_value = '0;
          out_data_nxt.out_of_range  = 1'b1;
        end else begin
          out_data_nxt.feature_value = acc_sat;
          out_data_nxt.out_of_range  = 1'b0;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      rd_cnt_r       <= '0;
      n_r            <= '0;
      bad_r          <= 1'b0;
      rd_vld_r       <= 1'b0;
      box_vld_r      <= 1'b0;
      prod_vld_r     <= 1'b0;
      out_strobe_r   <= 1'b0;
      region_count_r <= RESET_REGION_COUNT;
      weights_r      <= '0;
      for (int k = 0; k < NUM_BOUNDS; k++) begin
        bounds_r[k] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      n_r          <= n_nxt;
      bad_r        <= bad_nxt;
      rd_vld_r     <= (state_r == S_READ);
      box_vld_r    <= rd_vld_r && (rd_crn_r == CRN_B);
      prod_vld_r   <= box_vld_r;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        case (cfg_index) inside
          REG_COUNT: begin
            region_count_r <= cfg_wdata[CNT_W-1:0];
          end
          [REG_BOUNDS_0:REG_BOUNDS_3]: begin
            bounds_r[REG_SEL_W'(cfg_index - REG_BOUNDS_0)] <= cfg_wdata[BOUNDS_W-1:0];
          end
          REG_WEIGHTS: begin
            weights_r <= cfg_wdata;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept && (in_data.func == FUNC_EVAL)) begin
      pos_x_r <= in_data.pos_x;
      pos_y_r <= in_data.pos_y;
    end
    rd_crn_r    <= rd_crn;
    rd_reg_r    <= rd_cnt_r[REG_SEL_W+CRN_W-1:CRN_W];
    rd_last_r   <= rd_last;
    if (rd_vld_r) begin
      box_r <= box_nxt;
    end
    box_reg_r   <= rd_reg_r;
    box_last_r  <= rd_last_r;
    prod_r      <= prod_nxt;
    prod_last_r <= box_last_r;
    if (state_r == S_CHECK) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    out_data_r <= out_data_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // An evaluate request makes the block busy; a write request does not.
  a_busy_follows_func: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy == $past(in_data.func)))
    else $error("busy does not follow the accepted request function");

  // A result leaves only from the finishing state.
  a_strobe_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_DONE))
    else $error("result strobe without a finished evaluation");

  // Memory reads are issued only by the read phase.
  a_read_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == S_READ))
    else $error("corner read outside the read phase");

  // An out-of-range result carries a zero value.
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.out_of_range) |-> (out_data.feature_value == '0))
    else $error("out-of-range result with a nonzero value");

endmodule

>>> tb/sv/haar_feature_from_integral_image_test.sv
`timescale 1ns / 100ps
// ============================================================================
// haar_feature_from_integral_image_test: self-checking Haar feature bench
// Fills the integral image through write requests and checks each evaluate
// request against a local predictor. The predictor covers weighted
// rectangles, out-of-image corners and saturation. Registers change between
// phases; requests come in random bursts.
// ============================================================================
module haar_feature_from_integral_image_test;
  import haar_pkg::*;

  localparam int IMG_ROWS     = DEF_IMG_ROWS;
  localparam int IMG_COLS     = DEF_IMG_COLS;
  localparam int MAX_REGIONS  = DEF_MAX_REGIONS;
  localparam int DRAIN_CYCLES = 30;
  localparam int LIMIT_NS     = 2_000_000;

  // Indexes past the end of the register list; the block must ignore them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
  localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};
  localparam longint FEAT_MAX = (longint'(1) <<< (FEAT_W - 1)) - 1;
  localparam longint FEAT_MIN = -FEAT_MAX - 1;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  haar_req_t             in_data   = '0;
  logic                  out_strobe;
  haar_res_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Requests waiting for the driver and features waiting for the block.
  haar_req_t req_q[$];
  haar_res_t feature_q[$];

  // Predictor copy of the registers and of the integral image.
  logic [CNT_W-1:0]          region_cnt = RESET_REGION_COUNT;
  logic [BOUNDS_W-1:0]       region_bounds [0:NUM_BOUNDS-1] = '{default: '0};
  logic [CFG_DATA_W-1:0]     region_weights = '0;
  logic signed [ENTRY_W-1:0] img_store [0:IMG_ROWS*IMG_COLS-1];

  // Entries already written by queued requests; evaluations only read these.
  bit written_map [0:IMG_ROWS*IMG_COLS-1] = '{default: 1'b0};

  int queued_cnt   = 0;
  int gap_left     = 0;
  int burst_left   = 0;
  int fail_cnt     = 0;
  int checked_cnt  = 0;
  int eval_cnt     = 0;
  int write_cnt    = 0;
  int outside_cnt  = 0;
  int sat_cnt      = 0;
  int settings_cnt = 0;
  haar_res_t want_res;

  haar_feature_from_integral_image #(
    .IMG_ROWS   (IMG_ROWS),
    .IMG_COLS   (IMG_COLS),
    .MAX_REGIONS(MAX_REGIONS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Register write as the block decodes it; unknown indexes change nothing.
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_COUNT) begin
      region_cnt = val[CNT_W-1:0];
    end else if (idx >= REG_BOUNDS_0 && idx <= REG_BOUNDS_3) begin
      region_bounds[idx - REG_BOUNDS_0] = val[BOUNDS_W-1:0];
    end else if (idx == REG_WEIGHTS) begin
      region_weights = val;
    end
  endfunction

  function automatic int used_regions();
    return (region_cnt > MAX_REGIONS) ? MAX_REGIONS : int'(region_cnt);
  endfunction

  function automatic bit in_image(int r, int c);
    return r >= 0 && r < IMG_ROWS && c >= 0 && c < IMG_COLS;
  endfunction

  // Row and column of one corner of rectangle k at window (px, py).
  function automatic void corner_rc(int k, logic [CRN_W-1:0] crn, int px, int py,
                                    output int r, output int c);
    logic [BOUNDS_W-1:0] b;
    int x1, x2, y1, y2;
    b  = region_bounds[k];
    x1 = px + int'(b[7:0]);
    x2 = px + int'(b[15:8]);
    y1 = py + int'(b[23:16]);
    y2 = py + int'(b[31:24]);
    r  = 0;
    c  = 0;
    case (crn)
      CRN_D: begin r = y2;     c = x2;     end
      CRN_A: begin r = y1 - 1; c = x1 - 1; end
      CRN_C: begin r = y2;     c = x1 - 1; end
      CRN_B: begin r = y1 - 1; c = x2;     end
      default: ;
    endcase
  endfunction

  // Weighted sum of box sums at a window, saturated to the result width.
  function automatic haar_res_t predict_feature(int px, int py);
    haar_res_t               res;
    longint                  acc, box, corner_val;
    logic signed [WT_W-1:0]  wt;
    logic [CRN_W-1:0]        crn;
    int                      r, c, n;
    bit                      outside;
    acc     = 0;
    outside = 1'b0;
    n       = used_regions();
    for (int k = 0; k < n; k++) begin
      for (int q = 0; q < 4; q++) begin
        corner_rc(k, CRN_W'(q), px, py, r, c);
        if (!in_image(r, c)) outside = 1'b1;
      end
    end
    if (!outside) begin
      for (int k = 0; k < n; k++) begin
        box = 0;
        for (int q = 0; q < 4; q++) begin
          crn = CRN_W'(q);
          corner_rc(k, crn, px, py, r, c);
          corner_val = img_store[r * IMG_COLS + c];
          if (crn == CRN_D || crn == CRN_A) box += corner_val;
          else box -= corner_val;
        end
        wt  = region_weights[WT_W*k +: WT_W];
        acc += box * longint'(wt);
      end
    end else begin
      outside_cnt++;
    end
    if (acc > FEAT_MAX) begin
      acc = FEAT_MAX;
      sat_cnt++;
    end else if (acc < FEAT_MIN) begin
      acc = FEAT_MIN;
      sat_cnt++;
    end
    res.feature_value = acc[FEAT_W-1:0];
    res.out_of_range  = outside;
    return res;
  endfunction

  // Applies one accepted request to the predictor.
  function automatic void record_request(haar_req_t req);
    if (req.func == FUNC_WRITE) begin
      write_cnt++;
      if (in_image(req.row, req.col)) img_store[req.row * IMG_COLS + req.col] = req.entry_value;
    end else begin
      eval_cnt++;
      feature_q.push_back(predict_feature(req.pos_x, req.pos_y));
    end
  endfunction

  // A request with every field random; callers overwrite what matters.
  function automatic haar_req_t noise_req();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(haar_req_t)-1:0];
  endfunction

  function automatic logic signed [ENTRY_W-1:0] pick_entry();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return ENTRY_MAX;
      1: return ENTRY_MIN;
      2: return '1;
      3: return ENTRY_W'(raw[9:0]);
      default: return raw[ENTRY_W-1:0];
    endcase
  endfunction

  // Mostly small rectangles near the window, sometimes one far past the edge.
  function automatic logic [BOUNDS_W-1:0] pick_bounds();
    logic [OFF_W-1:0] x1, x2, y1, y2;
    x1 = $urandom_range(0, 3);
    y1 = $urandom_range(0, 3);
    x2 = x1 + $urandom_range(0, 6);
    y2 = y1 + $urandom_range(0, 6);
    if ($urandom_range(0, 5) == 0) x2 = $urandom_range(0, 255);
    if ($urandom_range(0, 5) == 0) y2 = $urandom_range(0, 255);
    return {y2, y1, x2, x1};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_weights();
    logic [CFG_DATA_W-1:0] w;
    for (int k = 0; k < MAX_REGIONS; k++) begin
      case ($urandom_range(0, 7))
        0: w[WT_W*k +: WT_W] = 16'h7FFF;
        1: w[WT_W*k +: WT_W] = 16'h8000;
        2: w[WT_W*k +: WT_W] = 16'h0100;  // +256
        3: w[WT_W*k +: WT_W] = 16'hFF00;  // -256
        default: w[WT_W*k +: WT_W] = $urandom;
      endcase
    end
    return w;
  endfunction

  function automatic void push_write(int r, int c, logic signed [ENTRY_W-1:0] val);
    haar_req_t req;
    req             = noise_req();
    req.func        = FUNC_WRITE;
    req.row         = POS_W'(r);
    req.col         = POS_W'(c);
    req.entry_value = val;
    req_q.push_back(req);
    written_map[r * IMG_COLS + c] = 1'b1;
    queued_cnt++;
  endfunction

  // Evaluate request, preceded by writes of any in-image corner not yet set.
  function automatic void push_eval(int px, int py);
    haar_req_t req;
    int        r, c;
    for (int k = 0; k < used_regions(); k++) begin
      for (int q = 0; q < 4; q++) begin
        corner_rc(k, CRN_W'(q), px, py, r, c);
        if (in_image(r, c) && !written_map[r * IMG_COLS + c]) push_write(r, c, pick_entry());
      end
    end
    req       = noise_req();
    req.func  = FUNC_EVAL;
    req.pos_x = POS_W'(px);
    req.pos_y = POS_W'(py);
    req_q.push_back(req);
    queued_cnt++;
  endfunction

  // Writes every register back to back, upper data bits filled with noise.
  task automatic program_regs(input logic [CNT_W-1:0] cnt, input logic [4*BOUNDS_W-1:0] bnds,
                              input logic [CFG_DATA_W-1:0] wts, input bit with_spare);
    logic [CFG_IDX_W-1:0]  idx_list [0:7];
    logic [CFG_DATA_W-1:0] val_list [0:7];
    logic [63:0]           raw;
    int                    n;
    raw         = {$urandom, $urandom};
    idx_list[0] = REG_COUNT;
    val_list[0] = {raw[63:CNT_W], cnt};
    for (int k = 0; k < NUM_BOUNDS; k++) begin
      idx_list[k+1] = REG_BOUNDS_0 + CFG_IDX_W'(k);
      val_list[k+1] = {raw[63:BOUNDS_W], bnds[BOUNDS_W*k +: BOUNDS_W]};
    end
    idx_list[5] = REG_WEIGHTS;
    val_list[5] = wts;
    idx_list[6] = REG_SPARE_A;
    val_list[6] = '1;
    idx_list[7] = REG_SPARE_B;
    val_list[7] = raw;
    n = with_spare ? 8 : 6;
    for (int i = 0; i < n; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_wdata <= val_list[i];
      apply_reg(idx_list[i], val_list[i]);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_cnt++;
  endtask

  // Waits until every request is taken and every feature has come back.
  task automatic wait_idle();
    @(negedge clk);
    while (req_q.size() != 0 || start || feature_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Request driver: random bursts with random gaps, holding start while busy.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) record_request(in_data);
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (req_q.size() != 0) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 16);
        in_data <= req_q.pop_front();
        start   <= 1'b1;
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor: every strobe must match the oldest predicted feature.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (feature_q.size() == 0) begin
        $error("feature result with no evaluate request pending: value %0d, out_of_range %0b",
               out_data.feature_value, out_data.out_of_range);
        fail_cnt++;
      end else begin
        want_res = feature_q.pop_front();
        checked_cnt++;
        if (out_data.feature_value !== want_res.feature_value) begin
          $error("feature_value: expected %0d, actual %0d",
                 want_res.feature_value, out_data.feature_value);
          fail_cnt++;
        end
        if (out_data.out_of_range !== want_res.out_of_range) begin
          $error("out_of_range: expected %0b, actual %0b",
                 want_res.out_of_range, out_data.out_of_range);
          fail_cnt++;
        end
      end
    end
  end

  // Stimulus: directed cases first, then random phases over several settings.
  initial begin
    logic [CFG_DATA_W-1:0] wts;
    int                    target;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: two 1x1 rectangles at the window position with zero weight.
    @(negedge clk);
    push_eval(0, 0);
    push_eval(10, 10);
    push_eval(IMG_COLS - 1, IMG_ROWS - 1);
    wait_idle();

    // Four identical 2x2 boxes over extreme entries, all weights at -32768.
    program_regs(3'd4, {4{32'h0201_0201}}, {4{16'h8000}}, 1'b0);
    @(negedge clk);
    push_write(22, 22, ENTRY_MAX);
    push_write(20, 20, ENTRY_MAX);
    push_write(22, 20, ENTRY_MIN);
    push_write(20, 22, ENTRY_MIN);
    push_eval(20, 20);
    push_eval(IMG_COLS - 2, 20);
    push_eval(20, IMG_ROWS - 2);
    wait_idle();

    // Count above the maximum, weights at their top, writes past the list.
    program_regs(3'd7, {4{32'h0201_0201}}, {4{16'h7FFF}}, 1'b1);
    @(negedge clk);
    push_eval(20, 20);
    wait_idle();

    // No rectangles at all: even a window at the origin is not out of range.
    program_regs(3'd0, '1, '1, 1'b0);
    @(negedge clk);
    push_eval(0, 0);
    push_eval(20, 20);
    wait_idle();

    // Mixed small weights over three rectangles.
    program_regs(3'd3, {4{32'h0201_0201}}, 64'h0000_FFFF_0100_0001, 1'b0);
    @(negedge clk);
    push_eval(20, 20);
    wait_idle();

    // Random phases: every region count, random bounds and weights.
    for (int p = 0; p < 8; p++) begin
      wts = (p == 4) ? 64'h8000_7FFF_8000_7FFF : pick_weights();
      program_regs(CNT_W'(p), {pick_bounds(), pick_bounds(), pick_bounds(), pick_bounds()},
                   wts, p % 2 == 1);
      @(negedge clk);
      queued_cnt = 0;
      target     = (p == 0) ? 15 : 75;
      while (queued_cnt < target) begin
        case ($urandom_range(0, 9))
          7: push_eval($urandom_range(0, IMG_COLS - 1), $urandom_range(0, IMG_ROWS - 1));
          8, 9: push_write($urandom_range(0, IMG_ROWS - 1), $urandom_range(0, IMG_COLS - 1),
                           pick_entry());
          default: push_eval($urandom_range(0, 12), $urandom_range(0, 12));
        endcase
      end
      wait_idle();
    end

    $display("Covered %0d write and %0d evaluate requests over %0d register settings.",
             write_cnt, eval_cnt, settings_cnt);
    $display("Checked %0d features: %0d out of range, %0d saturated.",
             checked_cnt, outside_cnt, sat_cnt);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
rtl/haar_pkg.sv
rtl/haar_feature_from_integral_image.sv
tb/sv/haar_feature_from_integral_image_test.sv
